/* rtl/running_median_filter_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the running median filter
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_FILTER_DEFINES_SVH
`define RUNNING_MEDIAN_FILTER_DEFINES_SVH

// Generic form with explicit clock and active-low reset.
`define RMF_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("running_median_filter: assertion failed");

// Short form for modules that use the block's own clock and reset names.
`define RMF_ASSERT(lbl, prop) `RMF_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

/* rtl/rmf_pkg.sv */
// ----------------------------------------------------------------------------
// Running median filter package
// Shared data width, default window size and the link passed between cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int RMF_DATA_W      = 16;
    localparam int RMF_WINDOW_SIZE = 17;

    typedef struct packed {
        logic signed [RMF_DATA_W-1:0] value;
        logic                         le;
        logic                         ev_out;
    } t_link;

endpackage

/* rtl/rmf_cell.sv */
// ----------------------------------------------------------------------------
// Running median filter sorting cell
// Holds one window entry and its age; on each word it keeps its entry, takes
// a neighbor's entry or takes the new sample, so the chain stays sorted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmf_cell #(
    parameter int WINDOW_SIZE = rmf_pkg::RMF_WINDOW_SIZE,
    parameter int AGE_W       = $clog2(rmf_pkg::RMF_WINDOW_SIZE),
    parameter int RESET_AGE   = 0,
    parameter bit IS_FIRST    = 1'b0,
    parameter bit IS_LAST     = 1'b0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic signed [rmf_pkg::RMF_DATA_W-1:0] i_sample,
    input  rmf_pkg::t_link                       i_lo,
    input  logic [AGE_W-1:0]                     i_lo_age,
    input  rmf_pkg::t_link                       i_hi,
    input  logic [AGE_W-1:0]                     i_hi_age,
    output rmf_pkg::t_link                       o_link,
    output logic [AGE_W-1:0]                     o_age
);

    logic signed [rmf_pkg::RMF_DATA_W-1:0] r_value, n_value;
    logic [AGE_W-1:0]                      r_age, n_age;

    logic                                  ev_here, ev_below, ev_up, le_self;
    logic                                  up_exists, up_le, dn_exists, dn_le;
    logic signed [rmf_pkg::RMF_DATA_W-1:0] up_val, dn_val;
    logic [AGE_W-1:0]                      up_age, dn_age;

    assign ev_here  = (r_age == AGE_W'(WINDOW_SIZE - 1));
    assign ev_below = IS_FIRST ? 1'b0 : i_lo.ev_out;
    assign ev_up    = ev_below | ev_here;
    assign le_self  = (r_value <= i_sample);

    always_comb begin
        if (ev_up) begin
            up_exists = !IS_LAST;
            up_le     = i_hi.le;
            up_val    = i_hi.value;
            up_age    = i_hi_age;
        end else begin
            up_exists = 1'b1;
            up_le     = le_self;
            up_val    = r_value;
            up_age    = r_age;
        end
        if (ev_below) begin
            dn_exists = 1'b1;
            dn_le     = le_self;
            dn_val    = r_value;
            dn_age    = r_age;
        end else begin
            dn_exists = !IS_FIRST;
            dn_le     = i_lo.le;
            dn_val    = i_lo.value;
            dn_age    = i_lo_age;
        end
        if (up_exists && up_le) begin
            n_value = up_val;
            n_age   = up_age + AGE_W'(1);
        end else if (!dn_exists || dn_le) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = dn_val;
            n_age   = dn_age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= AGE_W'(RESET_AGE);
        end else if (i_en) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link.value  = r_value;
    assign o_link.le     = le_self;
    assign o_link.ev_out = ev_up;
    assign o_age         = r_age;

endmodule

/* rtl/running_median_filter.sv */
// ----------------------------------------------------------------------------
// Running median filter
// Sliding-window median over the last WINDOW_SIZE signed 16-bit samples.
// ----------------------------------------------------------------------------
// The slave stream carries one sample per word; the master stream returns
// one median word for every sample word accepted, in the same order.
// The window is a row of sorting cells, each holding one entry and its age.
// When a word is accepted, the oldest entry drops out, the new sample is
// inserted at its sorted place and every cell updates in the same cycle.
// The median is the entry of the middle cell, which is the output register.
// o_m_tvalid is raised in the cycle after a sample word is accepted.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the median word holds and o_s_tready follows
// i_m_tready, so one new sample is taken only as the waiting word leaves.
// Reset clears every entry to zero, so the first medians include zeros,
// and clears o_m_tvalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_filter #(
    parameter int WINDOW_SIZE = rmf_pkg::RMF_WINDOW_SIZE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rmf_pkg::RMF_DATA_W-1:0]    i_s_tdata,  // [15:0] sample
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rmf_pkg::RMF_DATA_W-1:0]    o_m_tdata   // [15:0] median
);

    localparam int AGE_W = $clog2(WINDOW_SIZE);
    localparam int MID   = (WINDOW_SIZE - 1) / 2;

    rmf_pkg::t_link   links [WINDOW_SIZE];
    logic [AGE_W-1:0] ages  [WINDOW_SIZE];

    logic r_valid, n_valid;
    logic in_fire;

    assign o_s_tready = !r_valid || i_m_tready;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign n_valid    = in_fire || (r_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        rmf_pkg::t_link   lo, hi;
        logic [AGE_W-1:0] lo_age, hi_age;

        if (g == 0) begin : g_lo_edge
            assign lo     = '0;
            assign lo_age = '0;
        end else begin : g_lo_link
            assign lo     = links[g-1];
            assign lo_age = ages[g-1];
        end

        if (g == WINDOW_SIZE - 1) begin : g_hi_edge
            assign hi     = '0;
            assign hi_age = '0;
        end else begin : g_hi_link
            assign hi     = links[g+1];
            assign hi_age = ages[g+1];
        end

        rmf_cell #(
            .WINDOW_SIZE (WINDOW_SIZE),
            .AGE_W       (AGE_W),
            .RESET_AGE   (g),
            .IS_FIRST    (g == 0),
            .IS_LAST     (g == WINDOW_SIZE - 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (in_fire),
            .i_sample (i_s_tdata),
            .i_lo     (lo),
            .i_lo_age (lo_age),
            .i_hi     (hi),
            .i_hi_age (hi_age),
            .o_link   (links[g]),
            .o_age    (ages[g])
        );
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = links[MID].value;

endmodule

/* rtl/rmf_checker.sv */
// ----------------------------------------------------------------------------
// Running median filter port checker
// Watches the stream ports of the filter for flow-control slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "running_median_filter_defines.svh"

module rmf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [rmf_pkg::RMF_DATA_W-1:0] i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [rmf_pkg::RMF_DATA_W-1:0] o_m_tdata
);

    logic s_fire;

    assign s_fire = i_s_tvalid && o_s_tready;

    `RMF_ASSERT(a_stall_holds, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
    `RMF_ASSERT(a_ready_follows, o_s_tready == (!o_m_tvalid || i_m_tready))
    `RMF_ASSERT(a_fire_gives_word, s_fire |=> o_m_tvalid)
    `RMF_ASSERT(a_no_extra_word, !s_fire && (!o_m_tvalid || i_m_tready) |=> !o_m_tvalid)
    `RMF_ASSERT(a_sample_known, s_fire |-> !$isunknown(i_s_tdata))

endmodule

bind running_median_filter rmf_checker u_rmf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
